>>> src/isat_pkg.sv
// ----------------------------------------------------------------------------
// isat_pkg
// Shared types and codes for the indexed scatter-add table.
// ----------------------------------------------------------------------------
`default_nettype none

package isat_pkg;

  // request kinds
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_UPDATE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ROW_BASE      = 2'd0;
  localparam logic [1:0] CFG_ROW_COUNT     = 2'd1;
  localparam logic [1:0] CFG_REGION_LENGTH = 2'd2;
  localparam logic [1:0] CFG_SCALE         = 2'd3;

  // register reset values
  localparam logic [31:0] ROW_BASE_RST      = 32'd0;
  localparam logic [8:0]  ROW_COUNT_RST     = 9'd256;
  localparam logic [4:0]  REGION_LENGTH_RST = 5'd16;
  localparam logic [31:0] SCALE_RST         = 32'd1;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take a new request into the holding registers
    logic decode;    // register address, range check and product
    logic mem_rd;    // read the addressed element
    logic mem_wr;    // write the addressed element
    logic out_load;  // fill the response register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       in_range;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> src/isat_ctrl.sv
// ----------------------------------------------------------------------------
// isat_ctrl
// Sequencer: accept, decode, fetch, finish for one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module isat_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire isat_pkg::sts_t sts,
  output isat_pkg::cmd_t     cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_FETCH  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  // input side is open only between requests
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.capture  = accept;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        case (sts.req_type) inside
          isat_pkg::REQ_LOAD,
          isat_pkg::REQ_UPDATE,
          isat_pkg::REQ_READ: state_next = S_FETCH;
          default:            state_next = S_IDLE;
        endcase
      end
      S_FETCH: begin
        cmd.mem_rd = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        case (sts.req_type) inside
          isat_pkg::REQ_LOAD,
          isat_pkg::REQ_UPDATE: begin
            cmd.mem_wr = sts.in_range;
            state_next = S_IDLE;
          end
          isat_pkg::REQ_READ: begin
            // hold until the response register can take the result
            if (sts.out_free) begin
              cmd.out_load = 1'b1;
              state_next   = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  // table writes only for in-range loads and updates
  a_wr_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_wr |-> sts.in_range &&
      (sts.req_type == isat_pkg::REQ_LOAD || sts.req_type == isat_pkg::REQ_UPDATE))
    else $error("table write outside a valid load or update");

  // a response is produced only for reads and only into a free slot
  a_out_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free && sts.req_type == isat_pkg::REQ_READ)
    else $error("response load without a read or a free slot");

  // finish always follows a fetch
  a_finish_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |-> ($past(state) == S_FETCH || $past(state) == S_FINISH))
    else $error("finish reached without a fetch");
`endif

endmodule

`default_nettype wire

>>> src/isat_dpath.sv
// ----------------------------------------------------------------------------
// isat_dpath
// Holding registers, configuration, range check, scaler, table memory and
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module isat_dpath #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_REGION = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               cfg_wr,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  // request fields
  input  wire logic [1:0]         req_type,
  input  wire logic [31:0]        row_index,
  input  wire logic [3:0]         element_pos,
  input  wire logic signed [31:0] data_value,
  // response
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output logic signed [31:0]      read_data,
  output logic                    read_valid,
  // control
  input  wire isat_pkg::cmd_t     cmd,
  output isat_pkg::sts_t          sts
);

  localparam int DEPTH  = MAX_ROWS * MAX_REGION;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // configuration registers
  logic [31:0] row_base;
  logic [8:0]  row_count;
  logic [4:0]  region_length;
  logic [31:0] scale;

  // holding registers for the request in flight
  logic [1:0]            hold_type;
  logic [31:0]           hold_row;
  logic [3:0]            hold_pos;
  logic [DATA_WIDTH-1:0] hold_val;

  // decoded request
  logic [ADDR_W-1:0]     addr;
  logic                  in_range;
  logic [DATA_WIDTH-1:0] prod;

  // table
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] wr_data;

  // decode logic
  logic [31:0]           rel;
  logic                  row_ok;
  logic                  pos_ok;
  logic [ADDR_W-1:0]     addr_next;
  logic [DATA_WIDTH-1:0] prod_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_base      <= isat_pkg::ROW_BASE_RST;
      row_count     <= isat_pkg::ROW_COUNT_RST;
      region_length <= isat_pkg::REGION_LENGTH_RST;
      scale         <= isat_pkg::SCALE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        isat_pkg::CFG_ROW_BASE:      row_base      <= cfg_data;
        isat_pkg::CFG_ROW_COUNT:     row_count     <= cfg_data[8:0];
        isat_pkg::CFG_REGION_LENGTH: region_length <= cfg_data[4:0];
        isat_pkg::CFG_SCALE:         scale         <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture request fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hold_type <= req_type;
      hold_row  <= row_index;
      hold_pos  <= element_pos;
      hold_val  <= data_value[DATA_WIDTH-1:0];
    end
  end

  // table row, range check, element address and scaled value
  assign rel       = hold_row - row_base;
  assign row_ok    = (rel < {23'd0, row_count}) && (rel < 32'(MAX_ROWS));
  assign pos_ok    = ({1'b0, hold_pos} < region_length) && (32'(hold_pos) < 32'(MAX_REGION));
  assign addr_next = ADDR_W'(ADDR_W'(rel[ROW_W-1:0]) * ADDR_W'(MAX_REGION))
                   + ADDR_W'(hold_pos);
  assign prod_next = DATA_WIDTH'(scale[DATA_WIDTH-1:0] * hold_val);

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      addr     <= addr_next;
      in_range <= row_ok && pos_ok;
      prod     <= prod_next;
    end
  end

  // load stores the value, update adds the scaled value
  assign wr_data = (hold_type == isat_pkg::REQ_LOAD) ? hold_val : (rd_data + prod);

  // table memory
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[addr];
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_data  <= in_range ? 32'($signed(rd_data)) : '0;
      read_valid <= in_range;
    end
  end

  // status to the controller
  assign sts.req_type = hold_type;
  assign sts.in_range = in_range;
  assign sts.out_free = !rsp_valid || !rsp_stall;

endmodule

`default_nettype wire

>>> src/indexed_scatter_add_table.sv
// Indexed scatter-add table. Holds MAX_ROWS rows of MAX_REGION elements of
// DATA_WIDTH bits in a single-port table memory. A load writes one element,
// an update adds scale times its value to one element (wrapping), and a read
// returns the element with a valid flag; the row is row_index minus row_base,
// and an item outside row_count rows or region_length positions changes
// nothing (a read then returns zero with read_valid low). Requests are taken
// one at a time through accept, decode with multiply, table read, and write
// or response, an order set by the single table port's read-then-write; an
// unused kind ends after decode. A read waits in its last cycle while the
// output register still holds an earlier response. Configuration is always
// ready; the user must write it only while the block is idle (not enforced).
// Table contents are undefined until written; there is no clearing pass.
// ----------------------------------------------------------------------------
// indexed_scatter_add_table
// Top level: sequencer plus datapath with table memory.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_scatter_add_table #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_REGION = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  // requests
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic [31:0]        row_index,
  input  wire logic [3:0]         element_pos,
  input  wire logic signed [31:0] data_value,
  // responses
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output logic signed [31:0]      read_data,
  output logic                    read_valid
);

  isat_pkg::cmd_t cmd;
  isat_pkg::sts_t sts;

  // configuration transfer completes every cycle it is offered
  assign cfg_ready = 1'b1;

  isat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  isat_dpath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_REGION (MAX_REGION),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_type    (req_type),
    .row_index   (row_index),
    .element_pos (element_pos),
    .data_value  (data_value),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .read_data   (read_data),
    .read_valid  (read_valid),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire

>>> dv/tb_indexed_scatter_add_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_scatter_add_table
// Self-checking bench for the indexed scatter-add table: drives load, update,
// read and unused requests under several register settings, predicts every
// read response from a shadow table and checks them in order.
// ----------------------------------------------------------------------------

module tb_indexed_scatter_add_table;

  localparam int MAX_ROWS   = 256;
  localparam int MAX_REGION = 16;
  localparam int DATA_WIDTH = 32;

  // request kind the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         kind;
    logic [31:0]        row;
    logic [3:0]         pos;
    logic signed [31:0] value;
  } request_t;

  // shadow table and in-order store of predicted read responses
  class table_scoreboard;
    typedef struct {
      logic [31:0] data;
      logic        ok;
    } readback_t;

    logic [31:0] row_base;
    logic [8:0]  row_count;
    logic [4:0]  region_length;
    logic [31:0] scale;
    logic [31:0] cells [int unsigned];
    int unsigned filled [$];
    readback_t   expected_reads [$];
    int errors, loads, updates, reads, reads_hit, skipped, unused, checked;

    function new();
      row_base      = isat_pkg::ROW_BASE_RST;
      row_count     = isat_pkg::ROW_COUNT_RST;
      region_length = isat_pkg::REGION_LENGTH_RST;
      scale         = isat_pkg::SCALE_RST;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        isat_pkg::CFG_ROW_BASE:      row_base = val;
        isat_pkg::CFG_ROW_COUNT:     row_count = val[8:0];
        isat_pkg::CFG_REGION_LENGTH: region_length = val[4:0];
        isat_pkg::CFG_SCALE:         scale = val;
        default: ;
      endcase
    endfunction

    function int unsigned rows_in_use();
      return (row_count < MAX_ROWS) ? row_count : MAX_ROWS;
    endfunction

    function int unsigned region_in_use();
      return (region_length < MAX_REGION) ? region_length : MAX_REGION;
    endfunction

    // table address of a request, and whether it falls inside the table
    function bit find_slot(logic [31:0] row, logic [3:0] pos, output int unsigned addr);
      logic [31:0] rel;
      rel = row - row_base;
      addr = rel * MAX_REGION + pos;
      return (rel < rows_in_use()) && (pos < region_in_use());
    endfunction

    function int pending();
      return expected_reads.size();
    endfunction

    // accepted request transfer: update the shadow table, queue read data
    function void note_request(request_t r);
      int unsigned addr;
      bit          hit;
      readback_t   rb;
      hit = find_slot(r.row, r.pos, addr);
      case (r.kind)
        isat_pkg::REQ_LOAD: begin
          if (hit) begin
            if (!cells.exists(addr)) filled.push_back(addr);
            cells[addr] = r.value;
            loads++;
          end else begin
            skipped++;
          end
        end
        isat_pkg::REQ_UPDATE: begin
          if (hit) begin
            cells[addr] = cells[addr] + scale * r.value;
            updates++;
          end else begin
            skipped++;
          end
        end
        isat_pkg::REQ_READ: begin
          rb.ok = hit;
          rb.data = '0;
          if (hit) begin
            rb.data = cells[addr];
            reads_hit++;
          end
          expected_reads.push_back(rb);
          reads++;
        end
        default: unused++;
      endcase
    endfunction

    // accepted response transfer: compare with the oldest prediction
    function void check_response(logic [31:0] data, logic ok);
      readback_t rb;
      if (expected_reads.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, read_data %h read_valid %b", $time, data, ok);
        return;
      end
      rb = expected_reads.pop_front();
      checked++;
      if (data !== rb.data) begin
        errors++;
        $display("%0t: read_data expected %h actual %h", $time, rb.data, data);
      end
      if (ok !== rb.ok) begin
        errors++;
        $display("%0t: read_valid expected %b actual %b", $time, rb.ok, ok);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = isat_pkg::CFG_ROW_BASE;
  logic [31:0]        cfg_data = '0;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [1:0]         req_type = isat_pkg::REQ_LOAD;
  logic [31:0]        row_index = '0;
  logic [3:0]         element_pos = '0;
  logic signed [31:0] data_value = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic signed [31:0] read_data;
  logic               read_valid;

  table_scoreboard board = new();
  bit calm = 1'b0;
  int squeeze_asks = 0;
  int phases = 0;

  indexed_scatter_add_table #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_REGION (MAX_REGION),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_type    (req_type),
    .row_index   (row_index),
    .element_pos (element_pos),
    .data_value  (data_value),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .read_data   (read_data),
    .read_valid  (read_valid)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one request transfer; valid is left high for a back-to-back follower
  task automatic send_request(logic [1:0] kind, logic [31:0] row, logic [3:0] pos,
                              logic [31:0] value);
    request_t r;
    r.kind = kind;
    r.row = row;
    r.pos = pos;
    r.value = value;
    req_valid <= 1'b1;
    req_type <= kind;
    row_index <= row;
    element_pos <= pos;
    data_value <= value;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    board.note_request(r);
  endtask

  // one register write transfer; the caller drops valid after the batch
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, val);
  endtask

  // wait for all reads to return, then cover loads and updates still in flight
  task automatic settle();
    req_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // random request, mostly in range and aimed at entries already loaded
  function automatic request_t pick_request(int read_pct);
    request_t    r;
    int unsigned rows, len, addr, roll;
    bit          found;
    rows = board.rows_in_use();
    len = board.region_in_use();
    r.row = $urandom;
    r.pos = $urandom_range(15, 0);
    r.value = $urandom;
    if ($urandom_range(7, 0) == 0) begin
      case ($urandom_range(4, 0))
        0: r.value = 32'h7FFF_FFFF;
        1: r.value = 32'h8000_0000;
        2: r.value = 32'hFFFF_FFFF;
        3: r.value = 32'd0;
        default: r.value = 32'd1;
      endcase
    end
    roll = $urandom_range(99, 0);
    if (roll < 4) r.kind = REQ_UNUSED;
    else if (roll < 4 + read_pct) r.kind = isat_pkg::REQ_READ;
    else r.kind = $urandom_range(1, 0) ? isat_pkg::REQ_LOAD : isat_pkg::REQ_UPDATE;
    if (r.kind == REQ_UNUSED) return r;

    // out of range: bad position or bad row
    if ($urandom_range(9, 0) == 0 || rows == 0 || len == 0) begin
      if (len < MAX_REGION && rows > 0 && $urandom_range(1, 0)) begin
        r.row = board.row_base + $urandom_range(rows - 1, 0);
        r.pos = $urandom_range(15, len);
      end else begin
        r.row = board.row_base + $urandom_range(32'hFFFF_FFFF, rows);
      end
      return r;
    end

    // updates and reads hit loaded entries, recent ones more often
    found = 1'b0;
    if (r.kind != isat_pkg::REQ_LOAD) begin
      for (int i = 0; i < 8 && !found && board.filled.size() > 0; i++) begin
        if ($urandom_range(1, 0) && board.filled.size() > 4)
          addr = board.filled[board.filled.size() - 1 - $urandom_range(3, 0)];
        else
          addr = board.filled[$urandom_range(board.filled.size() - 1, 0)];
        found = (addr / MAX_REGION < rows) && (addr % MAX_REGION < len);
      end
      if (found) begin
        r.row = board.row_base + addr / MAX_REGION;
        r.pos = addr % MAX_REGION;
        return r;
      end
      r.kind = isat_pkg::REQ_LOAD;
    end

    // in range load, often on a few low rows so later items revisit them
    if ($urandom_range(1, 0))
      r.row = board.row_base + $urandom_range((rows < 4) ? rows - 1 : 3, 0);
    else
      r.row = board.row_base + $urandom_range(rows - 1, 0);
    r.pos = $urandom_range(len - 1, 0);
    return r;
  endfunction

  // reprogram all registers while idle, then a run of random requests
  task automatic run_phase(logic [31:0] base, logic [8:0] count, logic [4:0] len,
                           logic [31:0] mult, int n, int read_pct, bit squeeze);
    request_t r;
    int       gap_pct;
    settle();
    write_reg(isat_pkg::CFG_ROW_BASE, base);
    write_reg(isat_pkg::CFG_ROW_COUNT, {23'd0, count});
    write_reg(isat_pkg::CFG_REGION_LENGTH, {27'd0, len});
    write_reg(isat_pkg::CFG_SCALE, mult);
    cfg_valid <= 1'b0;
    phases++;
    if (squeeze) squeeze_asks++;
    gap_pct = 0;
    for (int k = 0; k < n; k++) begin
      if (k % 20 == 0) gap_pct = $urandom_range(1, 0) ? 0 : 35;
      if (!calm && !squeeze && $urandom_range(99, 0) < gap_pct) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(4, 1)) @(posedge clk);
      end
      r = pick_request(read_pct);
      send_request(r.kind, r.row, r.pos, r.value);
    end
  endtask

  // response side: checks each transfer, stalls in bursts or one long hold
  initial begin : response_side
    int stall_left;
    int hold_left;
    int squeeze_seen;
    bit stall_next;
    stall_left = 0;
    hold_left = 0;
    squeeze_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) board.check_response(read_data, read_valid);
      if (squeeze_seen != squeeze_asks) begin
        squeeze_seen = squeeze_asks;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (!calm && $urandom_range(4, 0) == 0) begin
        stall_left = $urandom_range(4, 1) - 1;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      rsp_stall <= stall_next;
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // main sequence
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners under reset settings: extreme rows and values, wrap, ignored kinds
    send_request(isat_pkg::REQ_LOAD,   32'd0,         4'd0,  32'h8000_0000);
    send_request(isat_pkg::REQ_LOAD,   32'd255,       4'd15, 32'h7FFF_FFFF);
    send_request(isat_pkg::REQ_READ,   32'd0,         4'd0,  32'h0);
    send_request(isat_pkg::REQ_READ,   32'd255,       4'd15, 32'hFFFF_FFFF);
    send_request(isat_pkg::REQ_UPDATE, 32'd255,       4'd15, 32'd1);
    send_request(isat_pkg::REQ_UPDATE, 32'd0,         4'd0,  32'hFFFF_FFFF);
    send_request(isat_pkg::REQ_READ,   32'd0,         4'd0,  32'h0);
    send_request(isat_pkg::REQ_READ,   32'd255,       4'd15, 32'h0);
    send_request(REQ_UNUSED,           32'd0,         4'd0,  32'hFFFF_FFFF);
    send_request(REQ_UNUSED,           32'hFFFF_FFFF, 4'd15, 32'h0);
    send_request(isat_pkg::REQ_READ,   32'd0,         4'd0,  32'h0);
    send_request(isat_pkg::REQ_LOAD,   32'd256,       4'd3,  32'h1234_5678);
    send_request(isat_pkg::REQ_READ,   32'd256,       4'd3,  32'h0);
    send_request(isat_pkg::REQ_READ,   32'hFFFF_FFFF, 4'd15, 32'h0);
    send_request(isat_pkg::REQ_UPDATE, 32'd300,       4'd0,  32'h5555_AAAA);
    send_request(isat_pkg::REQ_LOAD,   32'd17,        4'd9,  32'h0);
    send_request(isat_pkg::REQ_UPDATE, 32'd17,        4'd9,  32'h7FFF_FFFF);
    send_request(isat_pkg::REQ_UPDATE, 32'd17,        4'd9,  32'h7FFF_FFFF);
    send_request(isat_pkg::REQ_READ,   32'd17,        4'd9,  32'h0);

    // register settings from extreme to random
    run_phase($urandom,       9'd256, 5'd16, 32'hFFFF_FFFF, 60, 30, 1'b0);
    run_phase(32'hFFFF_FFFF,  9'd1,   5'd1,  32'h8000_0000, 50, 30, 1'b0);
    run_phase($urandom,       9'd0,   5'd16, 32'd3,         30, 30, 1'b0);
    run_phase(32'hFFFF_FFF0,  9'd511, 5'd31, 32'h7FFF_FFFF, 60, 30, 1'b0);
    run_phase($urandom,       9'd37,  5'd0,  $urandom,      30, 30, 1'b0);
    run_phase(32'd0,          9'd256, 5'd16, 32'd0,         50, 30, 1'b0);
    run_phase($urandom,       9'd256, 5'd16, $urandom,      70, 80, 1'b1);
    run_phase($urandom, $urandom_range(256, 1), $urandom_range(16, 1), $urandom,
              100, 30, 1'b0);
    calm = 1'b1;
    run_phase($urandom, $urandom_range(256, 1), $urandom_range(16, 1), $urandom,
              80, 35, 1'b0);
    settle();

    $display("ran %0d register settings: %0d loads, %0d updates, %0d skipped, %0d unused",
             phases, board.loads, board.updates, board.skipped, board.unused);
    $display("checked %0d read responses, %0d of them in range, %0d mismatches",
             board.checked, board.reads_hit, board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
src/isat_pkg.sv
src/isat_ctrl.sv
src/isat_dpath.sv
src/indexed_scatter_add_table.sv
dv/tb_indexed_scatter_add_table.sv
